// ===== sv/bsife_pkg.sv =====
// Shared types and constants of the byte-stuffed information frame encoder.
`timescale 1ns / 1ps
`default_nettype none
package bsife_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] FLAG_RESET    = 8'h7E;
   localparam logic [7:0] ESCAPE_RESET  = 8'h7D;
   localparam logic [7:0] MASK_RESET    = 8'h20;
   localparam logic [7:0] ADDRESS_RESET = 8'h03;

   localparam logic [7:0] SEQ_CONTROL   = 8'h40;
   localparam logic [7:0] NOSEQ_CONTROL = 8'h00;

   typedef enum logic [1:0] {
      CSR_FLAG    = 2'd0,
      CSR_ESCAPE  = 2'd1,
      CSR_MASK    = 2'd2,
      CSR_ADDRESS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       first_byte;
      logic       final_byte;
      logic       seq_bit;
   } req_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_end;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] flag_value;
      logic [7:0] escape_value;
      logic [7:0] escape_mask;
      logic [7:0] address_value;
   } cfg_type;

   // One classified transaction handed from front to back.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       data_stuff;
      logic [7:0] chk_byte;
      logic       chk_stuff;
      logic       first_byte;
      logic       final_byte;
      logic       seq_bit;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FLAG,
      ST_ADDR,
      ST_CTRL,
      ST_HCHK,
      ST_DESC,
      ST_DATA,
      ST_CESC,
      ST_CHK,
      ST_CLOSE
   } step_type;

endpackage
`default_nettype wire

// ===== sv/bsife_front.sv =====
// Front end: configuration registers, running payload XOR and stuffing classification.
`timescale 1ns / 1ps
`default_nettype none
module bsife_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_wr_en,
   input  wire [1:0]               csr_index,
   input  wire [7:0]               csr_wdata,
   input  wire                     accept,
   input  wire bsife_pkg::req_type req,
   output bsife_pkg::cmd_type      cmd,
   output bsife_pkg::cfg_type      cfg
);

   bsife_pkg::cfg_type cfg_ff;
   logic [7:0]         parity_ff;
   logic [7:0]         parity_in;
   logic [7:0]         chk_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_value    <= bsife_pkg::FLAG_RESET;
         cfg_ff.escape_value  <= bsife_pkg::ESCAPE_RESET;
         cfg_ff.escape_mask   <= bsife_pkg::MASK_RESET;
         cfg_ff.address_value <= bsife_pkg::ADDRESS_RESET;
      end else if (csr_wr_en) begin
         unique case (bsife_pkg::csr_index_type'(csr_index))
            bsife_pkg::CSR_FLAG:    cfg_ff.flag_value    <= csr_wdata;
            bsife_pkg::CSR_ESCAPE:  cfg_ff.escape_value  <= csr_wdata;
            bsife_pkg::CSR_MASK:    cfg_ff.escape_mask   <= csr_wdata;
            bsife_pkg::CSR_ADDRESS: cfg_ff.address_value <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Restart the XOR on a first byte, clear it after a final byte.
   always_comb begin
      chk_byte  = (req.first_byte ? 8'h00 : parity_ff) ^ req.payload_byte;
      parity_in = parity_ff;
      if (accept) begin
         parity_in = req.final_byte ? 8'h00 : chk_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 8'h00;
      end else begin
         parity_ff <= parity_in;
      end
   end

   always_comb begin
      cmd.data_byte  = req.payload_byte;
      cmd.data_stuff = (req.payload_byte == cfg_ff.flag_value) ||
                       (req.payload_byte == cfg_ff.escape_value);
      cmd.chk_byte   = chk_byte;
      cmd.chk_stuff  = (chk_byte == cfg_ff.flag_value) ||
                       (chk_byte == cfg_ff.escape_value);
      cmd.first_byte = req.first_byte;
      cmd.final_byte = req.final_byte;
      cmd.seq_bit    = req.seq_bit;
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== sv/bsife_queue.sv =====
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module bsife_queue #(
   parameter int unsigned DEPTH = bsife_pkg::QUEUE_DEPTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire bsife_pkg::cmd_type push_cmd,
   input  wire                     pop,
   output logic                    full,
   output logic                    not_empty,
   output bsife_pkg::cmd_type      head_cmd
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   bsife_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ===== sv/bsife_back.sv =====
// Back end: steps through the line bytes of the head command into the output register.
`timescale 1ns / 1ps
`default_nettype none
module bsife_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire bsife_pkg::cfg_type cfg,
   input  wire                     head_valid,
   input  wire bsife_pkg::cmd_type head_cmd,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output bsife_pkg::rsp_type      rsp_payload
);

   bsife_pkg::step_type step_ff;
   bsife_pkg::step_type step_in;
   bsife_pkg::step_type cur_step;
   bsife_pkg::step_type after_step;
   bsife_pkg::step_type payload_step;
   bsife_pkg::step_type check_step;
   logic                done;
   logic                advance;
   logic [7:0]          ctrl_byte;
   logic [7:0]          line_byte;

   logic                rsp_valid_ff;
   bsife_pkg::rsp_type  rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= bsife_pkg::ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctrl_byte    = head_cmd.seq_bit ? bsife_pkg::SEQ_CONTROL : bsife_pkg::NOSEQ_CONTROL;
      payload_step = head_cmd.data_stuff ? bsife_pkg::ST_DESC : bsife_pkg::ST_DATA;
      check_step   = head_cmd.chk_stuff ? bsife_pkg::ST_CESC : bsife_pkg::ST_CHK;

      // Idle means the head command has not started yet.
      cur_step = step_ff;
      if (step_ff == bsife_pkg::ST_IDLE) begin
         cur_step = head_cmd.first_byte ? bsife_pkg::ST_FLAG : payload_step;
      end

      after_step = bsife_pkg::ST_IDLE;
      done       = 1'b0;
      line_byte  = cfg.flag_value;
      unique case (cur_step)
         bsife_pkg::ST_FLAG: begin
            line_byte  = cfg.flag_value;
            after_step = bsife_pkg::ST_ADDR;
         end
         bsife_pkg::ST_ADDR: begin
            line_byte  = cfg.address_value;
            after_step = bsife_pkg::ST_CTRL;
         end
         bsife_pkg::ST_CTRL: begin
            line_byte  = ctrl_byte;
            after_step = bsife_pkg::ST_HCHK;
         end
         bsife_pkg::ST_HCHK: begin
            line_byte  = cfg.address_value ^ ctrl_byte;
            after_step = payload_step;
         end
         bsife_pkg::ST_DESC: begin
            line_byte  = cfg.escape_value;
            after_step = bsife_pkg::ST_DATA;
         end
         bsife_pkg::ST_DATA: begin
            line_byte  = head_cmd.data_stuff ? (head_cmd.data_byte ^ cfg.escape_mask)
                                             : head_cmd.data_byte;
            after_step = check_step;
            done       = !head_cmd.final_byte;
         end
         bsife_pkg::ST_CESC: begin
            line_byte  = cfg.escape_value;
            after_step = bsife_pkg::ST_CHK;
         end
         bsife_pkg::ST_CHK: begin
            line_byte  = head_cmd.chk_stuff ? (head_cmd.chk_byte ^ cfg.escape_mask)
                                            : head_cmd.chk_byte;
            after_step = bsife_pkg::ST_CLOSE;
         end
         bsife_pkg::ST_CLOSE: begin
            line_byte  = cfg.flag_value;
            done       = 1'b1;
         end
         default: begin
            line_byte  = cfg.flag_value;
            done       = 1'b1;
         end
      endcase

      advance = head_valid && (!rsp_valid_ff || !rsp_stall);
      pop     = advance && done;
      step_in = step_ff;
      if (advance) begin
         step_in = done ? bsife_pkg::ST_IDLE : after_step;
      end
   end

   // Load the output register whenever it is empty or being taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff.line_byte <= line_byte;
         rsp_payload_ff.run_end   <= done;
         rsp_payload_ff.frame_end <= (cur_step == bsife_pkg::ST_CLOSE);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

// ===== sv/byte_stuffed_info_frame_encoder_unit.sv =====
// Top level of the byte-stuffed information frame encoder.
// Accepted transactions are queued; line bytes leave through the output register.
// Throughput: one line byte per cycle from the back-end step sequencer while rsp_stall
// is low; a plain byte yields 1 line byte, a stuffed byte 2, first+final stuffed up to 9.
// The command queue (QueueDepth entries) lets new transactions in while bytes drain.
// Reset is synchronous: control state and payload XOR clear, registers take 7E/7D/20/03.
`timescale 1ns / 1ps
`default_nettype none
module byte_stuffed_info_frame_encoder_unit #(
   parameter int unsigned QueueDepth = bsife_pkg::QUEUE_DEPTH
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_wr_en,
   input  wire [1:0]               csr_index,
   input  wire [7:0]               csr_wdata,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire bsife_pkg::req_type req_payload,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output bsife_pkg::rsp_type      rsp_payload
);

   bsife_pkg::cmd_type front_cmd;
   bsife_pkg::cmd_type head_cmd;
   bsife_pkg::cfg_type cfg;
   logic               q_full;
   logic               q_not_empty;
   logic               q_pop;
   logic               req_accept;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   bsife_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (req_accept),
      .req       (req_payload),
      .cmd       (front_cmd),
      .cfg       (cfg)
   );

   bsife_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_cmd  (front_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   bsife_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .head_valid  (q_not_empty),
      .head_cmd    (head_cmd),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
